// ----- src/vrej_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, types and limits of the 3d vector rejection pipeline
// no dependencies
package vrej_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int LANES = 3;           // x, y, z
    localparam int PW    = 2 * CW;      // one coordinate product
    localparam int DBBW  = 2 * CW;      // dot(b,b), unsigned
    localparam int DABW  = 2 * CW + 2;  // dot(a,b), signed
    localparam int PLW   = PW + 1;      // coordinate times low limb
    localparam int PHW   = PW + 2;      // coordinate times signed high limb
    localparam int NUMW  = 3 * CW + 2;  // numerator, signed
    localparam int QW    = CW + 2;      // quotient bits
    localparam int SW    = QW + 2;      // signed rounded quotient

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [PW-1:0]   prod_t;
    typedef logic signed [NUMW-1:0] num_t;
    typedef logic signed [SW-1:0]   quot_t;

    localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // control that travels with each word through the divider
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [LANES-1:0] neg;
    } meta_t;

endpackage

// ----- src/vector_rejection_3d.sv -----
`timescale 1ns / 1ps
// top level of the 3d vector rejection pipeline
// depends on vrej_pkg and vrej_div
//
// Computes the rejection of a from b, a - (dot(a,b)/dot(b,b)) * b, for signed
// fixed point coordinates. The result is the exact quotient
// (a_i*dot(b,b) - dot(a,b)*b_i) / dot(b,b), rounded to nearest with ties away
// from zero, then clamped to the coordinate range; saturated flags a clamp.
// A zero b gives zero components with zero_direction set. The block keeps no
// state and takes one word per cycle unless a finished word waits untaken. It
// has six stages of products, dot products, partial products, sums and
// magnitude, one stage per quotient bit of the restoring divider, and the
// rounding and clamp stage that is also the output register. When the output
// word is not taken, every stage holds, so nothing is lost or repeated.
module vector_rejection_3d
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  vrej_pkg::coord_t a_x,
    input  vrej_pkg::coord_t a_y,
    input  vrej_pkg::coord_t a_z,
    input  vrej_pkg::coord_t b_x,
    input  vrej_pkg::coord_t b_y,
    input  vrej_pkg::coord_t b_z,
    output logic             out_valid,
    input  logic             out_ready,
    output vrej_pkg::coord_t sep_x,
    output vrej_pkg::coord_t sep_y,
    output vrej_pkg::coord_t sep_z,
    output logic             zero_direction,
    output logic             saturated
);
    import vrej_pkg::*;

    coord_t in_a [LANES];
    coord_t in_b [LANES];
    assign in_a[0] = a_x;
    assign in_a[1] = a_y;
    assign in_a[2] = a_z;
    assign in_b[0] = b_x;
    assign in_b[1] = b_y;
    assign in_b[2] = b_z;

    // valid bits per stage
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;

    // whole pipe advances unless a finished word is waiting and not taken
    logic en;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: coordinate products
    coord_t a1_reg  [LANES];
    coord_t b1_reg  [LANES];
    prod_t  bb1_reg [LANES];
    prod_t  ab1_reg [LANES];

    // stage 2: dot products
    coord_t                  a2_reg [LANES];
    coord_t                  b2_reg [LANES];
    logic [DBBW-1:0]         dbb2_reg;
    logic signed [DABW-1:0]  dab2_reg;

    // stage 3: limb products of a_i*dbb and dab*b_i
    logic signed [PLW-1:0]   pa_lo3_reg [LANES];
    logic signed [PLW-1:0]   pa_hi3_reg [LANES];
    logic signed [PLW-1:0]   pb_lo3_reg [LANES];
    logic signed [PHW-1:0]   pb_hi3_reg [LANES];
    logic [DBBW-1:0]         dbb3_reg;
    logic                    zero3_reg;

    // stage 4: both full products
    num_t                    ta4_reg [LANES];
    num_t                    tb4_reg [LANES];
    logic [DBBW-1:0]         dbb4_reg;
    logic                    zero4_reg;

    // stage 5: numerator
    num_t                    num5_reg [LANES];
    logic [DBBW-1:0]         dbb5_reg;
    logic                    zero5_reg;

    // stage 6: magnitude and sign, into the divider
    meta_t                          meta6_reg;
    logic [LANES-1:0][NUMW-1:0]     mag6_reg;
    logic [DBBW-1:0]                dbb6_reg;

    // divider outputs
    meta_t                          dv_meta;
    logic [LANES-1:0][QW-1:0]       dv_quo;
    logic [LANES-1:0][DBBW-1:0]     dv_rem;
    logic [DBBW-1:0]                dv_den;

    // output stage
    coord_t sep_reg  [LANES];
    coord_t sep_next [LANES];
    logic   zero_reg;
    logic   sat_reg;
    logic   sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            s5_valid_reg    <= 1'b0;
            meta6_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg    <= in_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            meta6_reg.valid <= s5_valid_reg;
            meta6_reg.zero  <= zero5_reg;
            for (int i = 0; i < LANES; i++)
            begin
                meta6_reg.neg[i] <= num5_reg[i][NUMW-1];
            end
            out_valid_reg   <= dv_meta.valid;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                // stage 1
                a1_reg[i]  <= in_a[i];
                b1_reg[i]  <= in_b[i];
                bb1_reg[i] <= in_b[i] * in_b[i];
                ab1_reg[i] <= in_a[i] * in_b[i];
                // stage 2
                a2_reg[i]  <= a1_reg[i];
                b2_reg[i]  <= b1_reg[i];
                // stage 3, dbb split in two unsigned limbs, dab in low and signed high
                pa_lo3_reg[i] <= a2_reg[i] * $signed({1'b0, dbb2_reg[CW-1:0]});
                pa_hi3_reg[i] <= a2_reg[i] * $signed({1'b0, dbb2_reg[DBBW-1:CW]});
                pb_lo3_reg[i] <= b2_reg[i] * $signed({1'b0, dab2_reg[CW-1:0]});
                pb_hi3_reg[i] <= b2_reg[i] * $signed(dab2_reg[DABW-1:CW]);
                // stage 4
                ta4_reg[i] <= (NUMW'(pa_hi3_reg[i]) <<< CW) + NUMW'(pa_lo3_reg[i]);
                tb4_reg[i] <= (NUMW'(pb_hi3_reg[i]) <<< CW) + NUMW'(pb_lo3_reg[i]);
                // stage 5
                num5_reg[i] <= ta4_reg[i] - tb4_reg[i];
                // stage 6
                mag6_reg[i]      <= num5_reg[i][NUMW-1] ? NUMW'(-num5_reg[i])
                                                        : NUMW'(num5_reg[i]);
                // output
                sep_reg[i] <= sep_next[i];
            end
            dbb2_reg <= $unsigned(bb1_reg[0]) + $unsigned(bb1_reg[1])
                      + $unsigned(bb1_reg[2]);
            dab2_reg <= DABW'(ab1_reg[0]) + DABW'(ab1_reg[1]) + DABW'(ab1_reg[2]);
            dbb3_reg  <= dbb2_reg;
            zero3_reg <= (dbb2_reg == '0);
            dbb4_reg  <= dbb3_reg;
            zero4_reg <= zero3_reg;
            dbb5_reg  <= dbb4_reg;
            zero5_reg <= zero4_reg;
            dbb6_reg  <= dbb5_reg;
            zero_reg  <= dv_meta.zero;
            sat_reg   <= sat_next;
        end
    end

    vrej_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .meta_in  (meta6_reg),
        .mag_in   (mag6_reg),
        .den_in   (dbb6_reg),
        .meta_out (dv_meta),
        .quo      (dv_quo),
        .rem      (dv_rem),
        .den_out  (dv_den)
    );

    // round half away from zero, restore sign, clamp
    always_comb
    begin
        logic  inc;
        quot_t qmag;
        quot_t qval;
        sat_next = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            inc  = ({dv_rem[i], 1'b0} >= {1'b0, dv_den});
            qmag = quot_t'({2'b00, dv_quo[i]}) + quot_t'({{(SW-1){1'b0}}, inc});
            qval = dv_meta.neg[i] ? -qmag : qmag;
            if (dv_meta.zero)
            begin
                sep_next[i] = '0;
            end
            else if (qval > quot_t'(COORD_MAX))
            begin
                sep_next[i] = COORD_MAX;
                sat_next    = 1'b1;
            end
            else if (qval < quot_t'(COORD_MIN))
            begin
                sep_next[i] = COORD_MIN;
                sat_next    = 1'b1;
            end
            else
            begin
                sep_next[i] = qval[CW-1:0];
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign sep_x          = sep_reg[0];
    assign sep_y          = sep_reg[1];
    assign sep_z          = sep_reg[2];
    assign zero_direction = zero_reg;
    assign saturated      = sat_reg;

    // zero direction gives an all-zero, unclamped word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_direction |-> sep_x == '0 && sep_y == '0 && sep_z == '0
                                        && !saturated)
        else $error("zero direction word with nonzero payload");

    // a clamp leaves some component at a range end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> sep_x == COORD_MAX || sep_x == COORD_MIN
                                   || sep_y == COORD_MAX || sep_y == COORD_MIN
                                   || sep_z == COORD_MAX || sep_z == COORD_MIN)
        else $error("saturated flag without a clamped component");

    // an accepted word enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted word lost at pipeline entry");

endmodule

// ----- src/vrej_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring divider, three lanes over one shared divisor, one bit per stage
// depends on vrej_pkg
module vrej_div
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  vrej_pkg::meta_t                           meta_in,
    input  logic [vrej_pkg::LANES-1:0][vrej_pkg::NUMW-1:0] mag_in,
    input  logic [vrej_pkg::DBBW-1:0]                 den_in,
    output vrej_pkg::meta_t                           meta_out,
    output logic [vrej_pkg::LANES-1:0][vrej_pkg::QW-1:0]   quo,
    output logic [vrej_pkg::LANES-1:0][vrej_pkg::DBBW-1:0] rem,
    output logic [vrej_pkg::DBBW-1:0]                 den_out
);
    import vrej_pkg::*;

    // bits_reg holds the dividend bits still to come on top, quotient bits below
    logic [LANES-1:0][DBBW-1:0] rem_reg  [QW];
    logic [LANES-1:0][DBBW-1:0] rem_next [QW];
    logic [LANES-1:0][QW-1:0]   bits_reg  [QW];
    logic [LANES-1:0][QW-1:0]   bits_next [QW];
    logic [DBBW-1:0]            den_reg  [QW];
    meta_t                      meta_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [LANES-1:0][DBBW-1:0] rem_src;
        logic [LANES-1:0][QW-1:0]   bits_src;
        logic [DBBW-1:0]            den_src;

        if (k == 0) begin : g_first
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_src[l]  = mag_in[l][NUMW-1:QW];
                assign bits_src[l] = mag_in[l][QW-1:0];
            end
            assign den_src = den_in;
        end
        else begin : g_rest
            assign rem_src  = rem_reg[k-1];
            assign bits_src = bits_reg[k-1];
            assign den_src  = den_reg[k-1];
        end

        always_comb
        begin
            logic [DBBW:0] trial;
            logic          ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_src[l], bits_src[l][QW-1]};
                ge    = (trial >= {1'b0, den_src});
                if (ge)
                begin
                    rem_next[k][l] = DBBW'(trial - {1'b0, den_src});
                end
                else
                begin
                    rem_next[k][l] = trial[DBBW-1:0];
                end
                bits_next[k][l] = {bits_src[l][QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                meta_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            meta_reg[0] <= meta_in;
            for (int k = 1; k < QW; k++)
            begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den_in;
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                bits_reg[k] <= bits_next[k];
            end
            for (int k = 1; k < QW; k++)
            begin
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign meta_out = meta_reg[QW-1];
    assign quo      = bits_reg[QW-1];
    assign rem      = rem_reg[QW-1];
    assign den_out  = den_reg[QW-1];

endmodule
